@@ rtl/sks_pkg.sv @@
`default_nettype none

package sks_pkg;

  // Width of a key and of the command and status codes
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;

  // Commands carried by an input item
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;
  localparam logic [CMD_W-1:0] CMD_LIST   = 2'd3;

  // Status codes carried by a result item
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

  // What every cell does on the coming clock edge
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_DEL,
    OP_ROT
  } cell_op_t;

  // Broadcast control shared by the whole row of cells
  typedef struct packed {
    cell_op_t          op;
    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  head;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/sks_cell.sv @@
`default_nettype none

module sks_cell (
  input  wire logic                      clk,
  input  wire sks_pkg::cell_ctl_t        ctl,
  input  wire logic                      occ,
  input  wire logic                      wrap,
  input  wire logic                      lt_below,
  input  wire logic [sks_pkg::KEY_W-1:0] key_lo,
  input  wire logic [sks_pkg::KEY_W-1:0] key_hi,
  output logic      [sks_pkg::KEY_W-1:0] key_q,
  output logic                           lt,
  output logic                           eq
);
  import sks_pkg::*;

  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] key_nxt;

  // Compare the stored key with the broadcast key; an empty cell never matches.
  assign lt    = occ && ($signed(key_r) < $signed(ctl.key));
  assign eq    = occ && (key_r == ctl.key);
  assign key_q = key_r;

  // Cells at or above the sorted position shift up on insert and down on
  // remove; a list rotates the occupied part of the row towards cell zero.
  always_comb begin
    key_nxt = key_r;
    case (ctl.op)
      OP_INS: begin
        if (!lt) begin
          key_nxt = lt_below ? ctl.key : key_lo;
        end
      end
      OP_DEL: begin
        if (!lt) begin
          key_nxt = key_hi;
        end
      end
      OP_ROT: begin
        key_nxt = wrap ? ctl.head : key_hi;
      end
      default: begin
        key_nxt = key_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/sorted_key_set.sv @@
`default_nettype none

// Sorted set of distinct signed 32-bit keys, held in ascending order in a row
// of cells that all compare against the incoming key at once.
// Input channel: in_cmd and in_key, taken when in_valid is high and in_stall
// low. Insert, remove and search each give one result item with out_last set.
// List gives one result item per stored key, smallest first, with out_last on
// the largest; an empty set gives no result.
// An item is taken in the idle state; once the output register is free, every
// cell compares, the row shifts once if an insert or remove changes the set,
// and the result is registered. A list goes on to the list state instead,
// where the row rotates one place towards cell zero for each key shown. The
// next item is taken once the last result is in the output register.
// The output register holds its item while out_stall is high; the block waits
// with its next result until the register is free.
// Reset empties the set, clears the output valid and holds in_stall high;
// no clearing pass runs.
module sorted_key_set #(
  parameter int unsigned CAPACITY = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [sks_pkg::CMD_W-1:0]    in_cmd,
  input  wire logic signed [sks_pkg::KEY_W-1:0] in_key,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [sks_pkg::STATUS_W-1:0]      out_status,
  output logic                              out_found,
  output logic signed [sks_pkg::KEY_W-1:0]  out_key_out,
  output logic                              out_last
);
  import sks_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LIST
  } state_t;

  state_t              state_r;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    list_idx_r;
  logic [CMD_W-1:0]    cmd_r;
  logic [KEY_W-1:0]    key_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r;
  logic                found_r;
  logic [KEY_W-1:0]    key_out_r;
  logic                last_r;

  cell_ctl_t           ctl;
  logic [KEY_W-1:0]    cell_key [CAPACITY];
  logic [CAPACITY-1:0] lt_v;
  logic [CAPACITY-1:0] eq_v;
  logic                hit;
  logic                full;
  logic                slot_free;
  logic                list_end;
  logic                out_load;

  assign hit       = |eq_v;
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign slot_free = !out_valid_r || !out_stall;
  assign list_end  = (list_idx_r == count_r - CNT_W'(1));
  assign in_stall  = !rst_n || (state_r != S_IDLE);

  // A result item enters the output register on this edge.
  assign out_load  = slot_free &&
                     ((state_r == S_EXEC && cmd_r != CMD_LIST) || state_r == S_LIST);

  // Choose what the row of cells does on this edge
  always_comb begin
    ctl.op   = OP_HOLD;
    ctl.key  = key_r;
    ctl.head = cell_key[0];
    if (state_r == S_EXEC && slot_free) begin
      if (cmd_r == CMD_INSERT && !hit && !full) begin
        ctl.op = OP_INS;
      end else if (cmd_r == CMD_REMOVE && hit) begin
        ctl.op = OP_DEL;
      end
    end else if (state_r == S_LIST && slot_free) begin
      ctl.op = OP_ROT;
    end
  end

  // Row of cells; each sees its neighbours' keys and the one below's compare
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             occ;
    logic             wrap;
    logic             lt_below;
    logic [KEY_W-1:0] key_lo;
    logic [KEY_W-1:0] key_hi;

    assign occ  = (CNT_W'(i) < count_r);
    assign wrap = (count_r == CNT_W'(i + 1));

    if (i == 0) begin : g_first
      assign lt_below = 1'b1;
      assign key_lo   = key_r;
    end else begin : g_inner
      assign lt_below = lt_v[i-1];
      assign key_lo   = cell_key[i-1];
    end

    if (i == CAPACITY - 1) begin : g_top
      assign key_hi = cell_key[i];
    end else begin : g_below_top
      assign key_hi = cell_key[i+1];
    end

    sks_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .occ      (occ),
      .wrap     (wrap),
      .lt_below (lt_below),
      .key_lo   (key_lo),
      .key_hi   (key_hi),
      .key_q    (cell_key[i]),
      .lt       (lt_v[i]),
      .eq       (eq_v[i])
    );
  end

  // Sequencer, entry count and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      list_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // The output register loads a new item or empties once it is taken.
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r   <= in_cmd;
            key_r   <= in_key;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cmd_r == CMD_LIST) begin
            list_idx_r <= '0;
            state_r    <= (count_r == '0) ? S_IDLE : S_LIST;
          end else if (slot_free) begin
            key_out_r   <= key_r;
            last_r      <= 1'b1;
            found_r     <= hit;
            state_r     <= S_IDLE;
            case (cmd_r)
              CMD_INSERT: begin
                if (hit) begin
                  status_r <= ST_DUP;
                end else if (full) begin
                  status_r <= ST_FULL;
                end else begin
                  status_r <= ST_OK;
                  count_r  <= count_r + CNT_W'(1);
                end
              end
              CMD_REMOVE: begin
                status_r <= hit ? ST_OK : ST_ABSENT;
                if (hit) begin
                  count_r <= count_r - CNT_W'(1);
                end
              end
              default: begin
                status_r <= hit ? ST_OK : ST_ABSENT;
              end
            endcase
          end
        end
        S_LIST: begin
          if (slot_free) begin
            status_r    <= ST_OK;
            found_r     <= 1'b1;
            key_out_r   <= cell_key[0];
            last_r      <= list_end;
            list_idx_r  <= list_idx_r + CNT_W'(1);
            if (list_end) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = status_r;
  assign out_found   = found_r;
  assign out_key_out = key_out_r;
  assign out_last    = last_r;

endmodule

`default_nettype wire

@@ rtl/sks_checker.sv @@
`default_nettype none

module sks_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_stall,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic [sks_pkg::STATUS_W-1:0]     out_status,
  input wire logic                             out_found,
  input wire logic signed [sks_pkg::KEY_W-1:0] out_key_out,
  input wire logic                             out_last
);
  import sks_pkg::*;

  // A held result item keeps its contents until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_key_out)
      && $stable(out_status) && $stable(out_last))
    else $error("result item changed while stalled");

  // The block shows in_stall in the cycle after it takes an item.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item taken on two consecutive cycles");

  // A duplicate insert reports the key as present and closes its item.
  a_dup: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_DUP) |-> out_found && out_last)
    else $error("duplicate result malformed");

  // Absent and full results never report the key as present.
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_ABSENT || out_status == ST_FULL)
      |-> !out_found && out_last)
    else $error("miss result malformed");

  // Only list entries can be followed by more results, and they are present.
  a_list: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_found && (out_status == ST_OK))
    else $error("non-final result is not a list entry");

endmodule

bind sorted_key_set sks_checker u_sks_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_status  (out_status),
  .out_found   (out_found),
  .out_key_out (out_key_out),
  .out_last    (out_last)
);

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import sks_pkg::*;

  localparam int unsigned CAPACITY     = 32;
  localparam int          RANDOM_ITEMS = 58;
  localparam int          HOLD_CYCLES  = 80;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          N_DIRECTED   = 25;

  localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
  localparam logic [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;
  localparam logic [KEY_W-1:0] KEY_NEG1 = 32'hFFFF_FFFF;

  // One result item as the block should deliver it.
  typedef struct {
    logic [STATUS_W-1:0]     status;
    logic                    found;
    logic signed [KEY_W-1:0] key;
    logic                    last;
  } set_result_t;

  // One row of the directed table; fixed_exp marks a row whose single result has its status and found typed in.
  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [KEY_W-1:0]    key;
    logic                fixed_exp;
    logic [STATUS_W-1:0] status;
    logic                found;
  } stim_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [CMD_W-1:0]        in_cmd;
  logic signed [KEY_W-1:0] in_key;
  logic                    out_valid;
  logic                    out_stall;
  logic [STATUS_W-1:0]     out_status;
  logic                    out_found;
  logic signed [KEY_W-1:0] out_key_out;
  logic                    out_last;

  // Shadow copy of the set, kept in ascending order, and the results still owed.
  logic signed [KEY_W-1:0] key_set[$];
  set_result_t             owed_results[$];

  int mismatches    = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int full_rejects  = 0;
  int list_entries  = 0;
  int burst_left    = 0;
  bit hold_request  = 1'b0;
  int holds_done    = 0;

  stim_row_t directed_rows [0:N_DIRECTED-1] = '{
    '{CMD_LIST,   32'd0,        1'b0, ST_OK,     1'b0},
    '{CMD_SEARCH, 32'd0,        1'b1, ST_ABSENT, 1'b0},
    '{CMD_REMOVE, 32'd5,        1'b1, ST_ABSENT, 1'b0},
    '{CMD_INSERT, KEY_MIN,      1'b1, ST_OK,     1'b0},
    '{CMD_INSERT, KEY_MAX,      1'b1, ST_OK,     1'b0},
    '{CMD_INSERT, 32'd0,        1'b1, ST_OK,     1'b0},
    '{CMD_INSERT, KEY_NEG1,     1'b1, ST_OK,     1'b0},
    '{CMD_INSERT, 32'd1,        1'b1, ST_OK,     1'b0},
    '{CMD_INSERT, KEY_MAX,      1'b1, ST_DUP,    1'b1},
    '{CMD_INSERT, 32'd0,        1'b1, ST_DUP,    1'b1},
    '{CMD_SEARCH, KEY_MIN,      1'b1, ST_OK,     1'b1},
    '{CMD_SEARCH, KEY_MAX,      1'b1, ST_OK,     1'b1},
    '{CMD_SEARCH, 32'd2,        1'b1, ST_ABSENT, 1'b0},
    '{CMD_LIST,   KEY_NEG1,     1'b0, ST_OK,     1'b0},
    '{CMD_INSERT, 32'hAAAA_AAAA, 1'b0, ST_OK,    1'b0},
    '{CMD_INSERT, 32'h5555_5555, 1'b0, ST_OK,    1'b0},
    '{CMD_REMOVE, KEY_MIN,      1'b1, ST_OK,     1'b1},
    '{CMD_REMOVE, KEY_MIN,      1'b1, ST_ABSENT, 1'b0},
    '{CMD_REMOVE, KEY_MAX,      1'b1, ST_OK,     1'b1},
    '{CMD_SEARCH, KEY_NEG1,     1'b1, ST_OK,     1'b1},
    '{CMD_LIST,   32'd0,        1'b0, ST_OK,     1'b0},
    '{CMD_REMOVE, 32'd0,        1'b1, ST_OK,     1'b1},
    '{CMD_LIST,   32'd7,        1'b0, ST_OK,     1'b0},
    '{CMD_SEARCH, 32'd0,        1'b1, ST_ABSENT, 1'b0},
    '{CMD_INSERT, 32'd0,        1'b1, ST_OK,     1'b0}
  };

  sorted_key_set #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_cmd     (in_cmd),
    .in_key     (in_key),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_found  (out_found),
    .out_key_out(out_key_out),
    .out_last   (out_last)
  );

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Print one line for a mismatch and count it.
  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // Apply one command to the shadow set and queue the results it owes.
  task automatic apply_to_key_set(input logic [CMD_W-1:0] cmd,
                                  input logic signed [KEY_W-1:0] key);
    int          pos;
    logic        hit;
    set_result_t res;
    if (cmd == CMD_LIST) begin
      foreach (key_set[i]) begin
        res.status = ST_OK;
        res.found  = 1'b1;
        res.key    = key_set[i];
        res.last   = (i == key_set.size() - 1);
        owed_results.push_back(res);
        list_entries++;
      end
      return;
    end
    pos = 0;
    while (pos < key_set.size() && key_set[pos] < key) pos++;
    hit = (pos < key_set.size()) && (key_set[pos] == key);
    res.key  = key;
    res.last = 1'b1;
    case (cmd)
      CMD_INSERT: begin
        if (hit) begin
          res.status = ST_DUP;
          res.found  = 1'b1;
        end else if (key_set.size() >= CAPACITY) begin
          res.status = ST_FULL;
          res.found  = 1'b0;
          full_rejects++;
        end else begin
          key_set.insert(pos, key);
          res.status = ST_OK;
          res.found  = 1'b0;
        end
      end
      CMD_REMOVE: begin
        if (hit) begin
          key_set.delete(pos);
          res.status = ST_OK;
          res.found  = 1'b1;
        end else begin
          res.status = ST_ABSENT;
          res.found  = 1'b0;
        end
      end
      default: begin
        res.status = hit ? ST_OK : ST_ABSENT;
        res.found  = hit;
      end
    endcase
    owed_results.push_back(res);
  endtask

  // Between items the sender either carries on its burst or idles for a while.
  task automatic sender_pause();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
        in_cmd   <= $urandom;
        in_key   <= $urandom;
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30)
                                               : $urandom_range(0, 6);
    end
  endtask

  // Offer one item, hold it until taken, then update the shadow set.
  task automatic offer_item(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                            input logic fixed_exp, input logic [STATUS_W-1:0] status,
                            input logic found);
    set_result_t res;
    @(negedge clk);
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_key   <= key;
    do @(posedge clk); while (in_stall);
    apply_to_key_set(cmd, $signed(key));
    // A typed-in row replaces the predicted status and found of its single result.
    if (fixed_exp) begin
      res = owed_results.pop_back();
      res.status = status;
      res.found  = found;
      owed_results.push_back(res);
    end
    items_sent++;
    sender_pause();
  endtask

  // Keys mostly come from a narrow range or from the set itself, so that hits are common.
  function automatic logic [KEY_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $signed($urandom_range(0, 40)) - 20;
    if (sel < 7 && key_set.size() > 0) return key_set[$urandom_range(0, key_set.size() - 1)];
    if (sel == 7) begin
      case ($urandom_range(0, 3))
        0: return KEY_MIN;
        1: return KEY_MAX;
        2: return KEY_NEG1;
        default: return '0;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 8) return CMD_INSERT;
    if (sel < 12) return CMD_REMOVE;
    if (sel < 17) return CMD_SEARCH;
    return CMD_LIST;
  endfunction

  // Receiver: stall pattern in windows of random length, plus long hold-offs on request.
  initial begin : receiver
    int mode;
    int window;
    int n;
    out_stall = 1'b0;
    forever begin
      mode   = $urandom_range(0, 3);
      window = $urandom_range(4, 32);
      for (int w = 0; w < window; w++) begin
        @(negedge clk);
        if (hold_request) begin
          out_stall <= 1'b1;
          for (n = 1; n < HOLD_CYCLES; n++) @(negedge clk);
          hold_request = 1'b0;
          holds_done++;
        end else begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= w[0];
          endcase
        end
      end
    end
  end

  // Compare every accepted result with the oldest one owed.
  always @(posedge clk) begin : check_results
    set_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (owed_results.size() == 0) begin
        flag_mismatch($sformatf("result with none owed: status %0d key %0d",
                                out_status, out_key_out));
      end else begin
        want = owed_results.pop_front();
        if (out_status !== want.status)
          flag_mismatch($sformatf("status %0d, expected %0d (key %0d)",
                                  out_status, want.status, want.key));
        if (out_found !== want.found)
          flag_mismatch($sformatf("found %0b, expected %0b (key %0d)",
                                  out_found, want.found, want.key));
        if (out_key_out !== want.key)
          flag_mismatch($sformatf("key_out %0d, expected %0d", out_key_out, want.key));
        if (out_last !== want.last)
          flag_mismatch($sformatf("last %0b, expected %0b (key %0d)",
                                  out_last, want.last, want.key));
      end
    end
  end

  // Give up on a hung run.
  initial begin : watchdog
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Stimulus: directed table, a fill to capacity, then random traffic.
  initial begin : stimulus
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_cmd   = CMD_INSERT;
    in_key   = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows.
    for (int r = 0; r < N_DIRECTED; r++)
      offer_item(directed_rows[r].cmd, directed_rows[r].key, directed_rows[r].fixed_exp,
                 directed_rows[r].status, directed_rows[r].found);

    // Fill the set to capacity, then probe the full cases.
    while (key_set.size() < CAPACITY)
      offer_item(CMD_INSERT, $urandom, 1'b0, ST_OK, 1'b0);
    repeat (3) offer_item(CMD_INSERT, $urandom, 1'b0, ST_OK, 1'b0);
    offer_item(CMD_INSERT, key_set[$urandom_range(0, CAPACITY - 1)], 1'b0, ST_OK, 1'b0);
    offer_item(CMD_INSERT, KEY_MIN, 1'b0, ST_OK, 1'b0);

    // A full list against a receiver that holds off, with more items queued behind it.
    hold_request = 1'b1;
    offer_item(CMD_LIST, $urandom, 1'b0, ST_OK, 1'b0);
    offer_item(CMD_SEARCH, key_set[0], 1'b0, ST_OK, 1'b0);
    offer_item(CMD_REMOVE, key_set[$urandom_range(0, CAPACITY - 1)], 1'b0, ST_OK, 1'b0);
    offer_item(CMD_INSERT, $urandom, 1'b0, ST_OK, 1'b0);
    offer_item(CMD_SEARCH, $urandom, 1'b0, ST_OK, 1'b0);

    // Random traffic.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 40) hold_request = 1'b1;
      offer_item(pick_cmd(), pick_key(), 1'b0, ST_OK, 1'b0);
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // Drain what is still owed, then watch for stray results.
    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items (%0d from the table) and checked %0d results.",
             items_sent, N_DIRECTED, results_seen);
    $display("Listed %0d keys, saw %0d inserts refused on a full set, %0d long hold-offs.",
             list_entries, full_rejects, holds_done);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
